// ===== hdl/assert_macros.svh =====
// assertion macros for the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ADNR_ASSERT(lbl, ck, rn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`define ADNR_NEVER(lbl, ck, rn, expr, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) else $error(msg);
`else
`define ADNR_ASSERT(lbl, ck, rn, prop, msg)
`define ADNR_NEVER(lbl, ck, rn, expr, msg)
`endif
`endif

// ===== hdl/adnr_pkg.sv =====
// types, constants and tables of the adpcm decoder and resampler
package adnr_pkg;
	localparam int OUTPUT_RATE = 529200;
	localparam int RATE_DIV = OUTPUT_RATE / 100;
	localparam int PH_W = 20;
	localparam int VAL_W = 12;
	localparam int STEP_MAX = 48;
	localparam int MAX_RESULTS = 24;
	localparam int CNT_W = 5;
	localparam int DIV_W = 21;
	localparam int RCP_W = 22;
	localparam int SH_100 = 27;
	localparam int SH_RATE = 34;
	localparam int SH_3 = 22;
	localparam longint RCP_100 = ((longint'(1) << SH_100) + 99) / 100;
	localparam longint RCP_RATE = ((longint'(1) << SH_RATE) + RATE_DIV - 1) / RATE_DIV;
	localparam longint RCP_3 = ((longint'(1) << SH_3) + 2) / 3;
	localparam int CO_W = 20;
	localparam int PROD_W = 29;

	localparam logic REG_PAN = 1'b0;
	localparam logic REG_CLK = 1'b1;

	typedef enum logic [1:0] {
		OP_CTRL = 2'd0,
		OP_DATA = 2'd1,
		OP_STATUS = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DSEL_PHASE,
		DSEL_INTERP,
		DSEL_THIRD
	} dsel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STAT,
		S_NIB,
		S_LOOP,
		S_DIV1,
		S_WAIT1,
		S_DIV2,
		S_WAIT2,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_DIV3,
		S_WAIT3,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic ld_item;
		logic dec;
		logic adv;
		logic nib_end;
		logic div_start;
		dsel_t div_sel;
		logic mul1;
		logic mul2;
		logic mul3;
		logic emit;
		logic stat;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		op_t op;
		logic playing;
		logic cnt_lt_rate;
		logic capped;
		logic nib;
		logic div_busy;
		logic out_free;
	} stat_t;

	function automatic logic [10:0] step_base(input logic [5:0] idx);
		logic [10:0] r;
		case (idx)
			6'd0: r = 11'd16;    6'd1: r = 11'd17;    6'd2: r = 11'd19;
			6'd3: r = 11'd21;    6'd4: r = 11'd23;    6'd5: r = 11'd25;
			6'd6: r = 11'd28;    6'd7: r = 11'd31;    6'd8: r = 11'd34;
			6'd9: r = 11'd37;    6'd10: r = 11'd41;   6'd11: r = 11'd45;
			6'd12: r = 11'd50;   6'd13: r = 11'd55;   6'd14: r = 11'd60;
			6'd15: r = 11'd66;   6'd16: r = 11'd73;   6'd17: r = 11'd80;
			6'd18: r = 11'd88;   6'd19: r = 11'd97;   6'd20: r = 11'd107;
			6'd21: r = 11'd118;  6'd22: r = 11'd130;  6'd23: r = 11'd143;
			6'd24: r = 11'd157;  6'd25: r = 11'd173;  6'd26: r = 11'd190;
			6'd27: r = 11'd209;  6'd28: r = 11'd230;  6'd29: r = 11'd253;
			6'd30: r = 11'd279;  6'd31: r = 11'd307;  6'd32: r = 11'd337;
			6'd33: r = 11'd371;  6'd34: r = 11'd408;  6'd35: r = 11'd449;
			6'd36: r = 11'd494;  6'd37: r = 11'd544;  6'd38: r = 11'd598;
			6'd39: r = 11'd658;  6'd40: r = 11'd724;  6'd41: r = 11'd796;
			6'd42: r = 11'd876;  6'd43: r = 11'd963;  6'd44: r = 11'd1060;
			6'd45: r = 11'd1166; 6'd46: r = 11'd1282; 6'd47: r = 11'd1411;
			6'd48: r = 11'd1552;
			default: r = 11'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [4:0] step_adjust(input logic [2:0] c);
		logic signed [4:0] r;
		case (c)
			3'd4: r = 5'sd2;
			3'd5: r = 5'sd4;
			3'd6: r = 5'sd6;
			3'd7: r = 5'sd8;
			default: r = -5'sd1;
		endcase
		return r;
	endfunction

	function automatic logic [PH_W-1:0] clock_rate(input logic [2:0] sel);
		logic [PH_W-1:0] r;
		case (sel)
			3'd0: r = PH_W'(93750);
			3'd1: r = PH_W'(125000);
			3'd2: r = PH_W'(187500);
			3'd3: r = PH_W'(125000);
			3'd4: r = PH_W'(46875);
			3'd5: r = PH_W'(62500);
			3'd6: r = PH_W'(93750);
			default: r = PH_W'(62500);
		endcase
		return r;
	endfunction
endpackage

// ===== hdl/adnr_if.sv =====
// valid/ready channel interfaces for input and result items
interface adnr_in_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [7:0] data;
	modport source (output valid, operation, data, input ready);
	modport sink (input valid, operation, data, output ready);
endinterface

interface adnr_out_if;
	logic valid;
	logic ready;
	logic kind;
	logic signed [11:0] right_sample;
	logic signed [11:0] left_sample;
	logic playing;
	logic last;
	modport source (output valid, kind, right_sample, left_sample, playing, last, input ready);
	modport sink (input valid, kind, right_sample, left_sample, playing, last, output ready);
endinterface

// ===== hdl/adnr_div.sv =====
// constant divider by reciprocal multiplication; the product is registered first, then the quotient
module adnr_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  adnr_pkg::dsel_t sel,
	input  logic [adnr_pkg::DIV_W-1:0] dividend,
	output logic busy,
	output logic [adnr_pkg::DIV_W-1:0] quot
);
	logic busy_q;
	adnr_pkg::dsel_t sel_q;
	logic [adnr_pkg::RCP_W-1:0] recip;
	logic [adnr_pkg::DIV_W+adnr_pkg::RCP_W-1:0] prod_q;
	logic [adnr_pkg::DIV_W-1:0] quot_n;
	logic [adnr_pkg::DIV_W-1:0] quot_q;

	always_comb begin
		case (sel)
			adnr_pkg::DSEL_PHASE: recip = adnr_pkg::RCP_W'(adnr_pkg::RCP_100);
			adnr_pkg::DSEL_INTERP: recip = adnr_pkg::RCP_W'(adnr_pkg::RCP_RATE);
			adnr_pkg::DSEL_THIRD: recip = adnr_pkg::RCP_W'(adnr_pkg::RCP_3);
			default: recip = '0;
		endcase
	end

	always_comb begin
		case (sel_q)
			adnr_pkg::DSEL_PHASE: quot_n = adnr_pkg::DIV_W'(prod_q >> adnr_pkg::SH_100);
			adnr_pkg::DSEL_INTERP: quot_n = adnr_pkg::DIV_W'(prod_q >> adnr_pkg::SH_RATE);
			adnr_pkg::DSEL_THIRD: quot_n = adnr_pkg::DIV_W'(prod_q >> adnr_pkg::SH_3);
			default: quot_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_q <= {{adnr_pkg::RCP_W{1'b0}}, dividend} * {{adnr_pkg::DIV_W{1'b0}}, recip};
			sel_q <= sel;
		end
		if (busy_q) quot_q <= quot_n;
	end

	assign busy = busy_q;
	assign quot = quot_q;
endmodule

// ===== hdl/adnr_ctrl.sv =====
// sequencer for decode, phase loop, interpolation steps and status items
module adnr_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  adnr_pkg::stat_t st,
	output adnr_pkg::cmd_t cmd,
	output logic in_ready
);
	adnr_pkg::state_t state_q;
	adnr_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adnr_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			adnr_pkg::S_IDLE: begin
				if (st.in_valid) begin
					case (st.op)
						adnr_pkg::OP_DATA: state_n = st.playing ? adnr_pkg::S_NIB
							: adnr_pkg::S_IDLE;
						adnr_pkg::OP_STATUS: state_n = adnr_pkg::S_STAT;
						default: state_n = adnr_pkg::S_IDLE;
					endcase
				end
			end
			adnr_pkg::S_STAT: if (st.out_free) state_n = adnr_pkg::S_IDLE;
			adnr_pkg::S_NIB: state_n = adnr_pkg::S_LOOP;
			adnr_pkg::S_LOOP: begin
				if (st.cnt_lt_rate) begin
					state_n = st.capped ? adnr_pkg::S_LOOP : adnr_pkg::S_DIV1;
				end else begin
					state_n = st.nib ? adnr_pkg::S_IDLE : adnr_pkg::S_NIB;
				end
			end
			adnr_pkg::S_DIV1: state_n = adnr_pkg::S_WAIT1;
			adnr_pkg::S_WAIT1: if (!st.div_busy) state_n = adnr_pkg::S_DIV2;
			adnr_pkg::S_DIV2: state_n = adnr_pkg::S_WAIT2;
			adnr_pkg::S_WAIT2: if (!st.div_busy) state_n = adnr_pkg::S_MUL1;
			adnr_pkg::S_MUL1: state_n = adnr_pkg::S_MUL2;
			adnr_pkg::S_MUL2: state_n = adnr_pkg::S_MUL3;
			adnr_pkg::S_MUL3: state_n = adnr_pkg::S_DIV3;
			adnr_pkg::S_DIV3: state_n = adnr_pkg::S_WAIT3;
			adnr_pkg::S_WAIT3: if (!st.div_busy) state_n = adnr_pkg::S_EMIT;
			adnr_pkg::S_EMIT: if (st.out_free) state_n = adnr_pkg::S_LOOP;
			default: state_n = adnr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = adnr_pkg::DSEL_PHASE;
		in_ready = 1'b0;
		case (state_q)
			adnr_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.ld_item = st.in_valid;
			end
			adnr_pkg::S_STAT: cmd.stat = st.out_free;
			adnr_pkg::S_NIB: cmd.dec = 1'b1;
			adnr_pkg::S_LOOP: begin
				cmd.adv = st.cnt_lt_rate & st.capped;
				cmd.nib_end = ~st.cnt_lt_rate;
			end
			adnr_pkg::S_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = adnr_pkg::DSEL_PHASE;
			end
			adnr_pkg::S_DIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = adnr_pkg::DSEL_INTERP;
			end
			adnr_pkg::S_MUL1: cmd.mul1 = 1'b1;
			adnr_pkg::S_MUL2: cmd.mul2 = 1'b1;
			adnr_pkg::S_MUL3: cmd.mul3 = 1'b1;
			adnr_pkg::S_DIV3: begin
				cmd.div_start = 1'b1;
				cmd.div_sel = adnr_pkg::DSEL_THIRD;
			end
			adnr_pkg::S_EMIT: begin
				cmd.emit = st.out_free;
				cmd.adv = st.out_free;
			end
			default: cmd = '0;
		endcase
	end
endmodule

// ===== hdl/adnr_dp.sv =====
// decoder state, phase accumulator, cubic interpolator and output register
`include "assert_macros.svh"
module adnr_dp (
	input  logic clk,
	input  logic arst_n,
	input  adnr_pkg::cmd_t cmd,
	output adnr_pkg::stat_t st,
	input  logic in_valid,
	input  logic [1:0] in_operation,
	input  logic [7:0] in_data,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [2:0] cfg_data,
	adnr_out_if.source out_ch
);
	logic [5:0] step_q;
	logic signed [adnr_pkg::VAL_W-1:0] value_q;
	logic signed [adnr_pkg::VAL_W-1:0] hist_q [4];
	logic empty_q;
	logic playing_q;
	logic [adnr_pkg::PH_W-1:0] phase_q;
	logic [1:0] pan_q;
	logic [2:0] csel_q;
	logic [adnr_pkg::CNT_W-1:0] count_q;
	logic nib_q;
	logic out_valid_q;

	logic [7:0] data_q;
	logic [7:0] x_q;
	logic signed [adnr_pkg::PROD_W-1:0] prod_q;
	logic sign_q;
	logic kind_q;
	logic signed [adnr_pkg::VAL_W-1:0] right_q;
	logic signed [adnr_pkg::VAL_W-1:0] left_q;
	logic play_out_q;
	logic last_q;

	logic [3:0] code;
	logic [14:0] mprod;
	logic [11:0] mag;
	logic signed [13:0] vsum;
	logic signed [adnr_pkg::VAL_W-1:0] vnew;
	logic signed [4:0] adj;
	logic signed [6:0] snext;
	logic [5:0] snew;

	logic [adnr_pkg::PH_W-1:0] clk_rate;
	logic [adnr_pkg::PH_W:0] cnt_next;
	logic cnt_lt_rate;
	logic capped;

	logic div_start;
	logic [adnr_pkg::DIV_W-1:0] dividend;
	logic div_busy;
	logic [adnr_pkg::DIV_W-1:0] quot;

	logic signed [adnr_pkg::CO_W-1:0] h0, h1, h2, h3;
	logic signed [adnr_pkg::CO_W-1:0] co_a, co_b, co_c;
	logic [7:0] x_new;
	logic signed [adnr_pkg::PROD_W-1:0] rv, rt;
	logic signed [adnr_pkg::CO_W-1:0] t_cur;
	logic signed [adnr_pkg::CO_W-1:0] mop;
	logic signed [8:0] xs;
	logic signed [adnr_pkg::PROD_W-1:0] mres;
	logic signed [adnr_pkg::PROD_W-1:0] v3, mag3;
	logic signed [adnr_pkg::CO_W-1:0] q3, t3, s_full;
	logic signed [adnr_pkg::VAL_W-1:0] s_clamp;
	logic out_free;
	logic last_n;

	// nibble decode
	assign code = nib_q ? data_q[7:4] : data_q[3:0];
	assign mprod = 15'(adnr_pkg::step_base(step_q)) * 15'({code[2:0], 1'b1});
	assign mag = mprod[14:3];
	assign vsum = code[3] ? 14'(value_q) - $signed({2'b00, mag})
		: 14'(value_q) + $signed({2'b00, mag});
	assign vnew = (vsum > 14'sd2047) ? 12'sd2047
		: (vsum < -14'sd2048) ? -12'sd2048 : vsum[11:0];
	assign adj = adnr_pkg::step_adjust(code[2:0]);
	assign snext = $signed({1'b0, step_q}) + {{2{adj[4]}}, adj};
	assign snew = (snext < 7'sd0) ? 6'd0
		: (snext > 7'(adnr_pkg::STEP_MAX)) ? 6'(adnr_pkg::STEP_MAX) : snext[5:0];

	// phase accumulator
	assign clk_rate = adnr_pkg::clock_rate(csel_q);
	assign cnt_next = {1'b0, phase_q} + {1'b0, clk_rate};
	assign cnt_lt_rate = phase_q < adnr_pkg::PH_W'(adnr_pkg::OUTPUT_RATE);
	assign capped = count_q == adnr_pkg::CNT_W'(adnr_pkg::MAX_RESULTS);

	// interpolator
	assign h0 = adnr_pkg::CO_W'(hist_q[0]);
	assign h1 = adnr_pkg::CO_W'(hist_q[1]);
	assign h2 = adnr_pkg::CO_W'(hist_q[2]);
	assign h3 = adnr_pkg::CO_W'(hist_q[3]);
	assign co_a = adnr_pkg::CO_W'(h3 - h0 + 3 * h1 - 3 * h2);
	assign co_b = adnr_pkg::CO_W'(3 * (h0 - 2 * h1 + h2));
	assign co_c = adnr_pkg::CO_W'(6 * h2 - 2 * h0 - 3 * h1 - h3);
	assign x_new = (quot > adnr_pkg::DIV_W'(255)) ? 8'd255 : quot[7:0];
	assign rv = prod_q + 29'sd128;
	assign rt = rv[adnr_pkg::PROD_W-1] ? (rv + 29'sd255) >>> 8 : rv >>> 8;
	assign t_cur = rt[adnr_pkg::CO_W-1:0];
	assign mop = cmd.mul1 ? co_a : cmd.mul2 ? t_cur + co_b : t_cur + co_c;
	assign xs = cmd.mul1 ? $signed({1'b0, x_new}) : $signed({1'b0, x_q});
	assign mres = mop * xs;
	assign v3 = prod_q + 29'sd768;
	assign mag3 = v3[adnr_pkg::PROD_W-1] ? -v3 : v3;
	assign q3 = $signed({1'b0, quot[adnr_pkg::CO_W-2:0]});
	assign t3 = sign_q ? -q3 : q3;
	assign s_full = t3 + h1;
	assign s_clamp = (s_full > 20'sd2047) ? 12'sd2047
		: (s_full < -20'sd2048) ? -12'sd2048 : s_full[11:0];
	assign last_n = (count_q == adnr_pkg::CNT_W'(adnr_pkg::MAX_RESULTS - 1))
		|| (nib_q && !(cnt_next < (adnr_pkg::PH_W + 1)'(adnr_pkg::OUTPUT_RATE)));

	// shared divider
	assign div_start = cmd.div_start;
	always_comb begin
		case (cmd.div_sel)
			adnr_pkg::DSEL_PHASE: dividend = {1'b0, phase_q};
			adnr_pkg::DSEL_INTERP: dividend = {quot[12:0], 8'd0};
			adnr_pkg::DSEL_THIRD: dividend = {1'b0, mag3[adnr_pkg::PROD_W-1:9]};
			default: dividend = '0;
		endcase
	end

	adnr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.sel(cmd.div_sel),
		.dividend(dividend),
		.busy(div_busy),
		.quot(quot)
	);

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			value_q <= '0;
			for (int i = 0; i < 4; i++) hist_q[i] <= '0;
			empty_q <= 1'b1;
			playing_q <= 1'b0;
			phase_q <= '0;
			pan_q <= 2'd3;
			csel_q <= 3'd2;
			count_q <= '0;
			nib_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					adnr_pkg::REG_PAN: pan_q <= cfg_data[1:0];
					adnr_pkg::REG_CLK: begin
						csel_q <= cfg_data;
						phase_q <= '0;
					end
					default: pan_q <= pan_q;
				endcase
			end
			if (cmd.ld_item) begin
				count_q <= '0;
				nib_q <= 1'b0;
				if (in_operation == adnr_pkg::OP_CTRL) begin
					if (in_data[0]) begin
						playing_q <= 1'b0;
					end else if (in_data[1]) begin
						if (!playing_q) begin
							step_q <= '0;
							value_q <= '0;
							playing_q <= 1'b1;
						end
						empty_q <= 1'b1;
					end
				end
			end
			if (cmd.dec) begin
				value_q <= vnew;
				step_q <= snew;
				empty_q <= 1'b0;
				if (empty_q) begin
					for (int i = 0; i < 4; i++) hist_q[i] <= vnew;
				end else begin
					hist_q[0] <= hist_q[1];
					hist_q[1] <= hist_q[2];
					hist_q[2] <= hist_q[3];
					hist_q[3] <= vnew;
				end
			end
			if (cmd.adv) begin
				phase_q <= cnt_next[adnr_pkg::PH_W-1:0];
			end
			if (cmd.nib_end) begin
				phase_q <= phase_q - adnr_pkg::PH_W'(adnr_pkg::OUTPUT_RATE);
				nib_q <= 1'b1;
			end
			if (cmd.emit) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.emit || cmd.stat) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_item) data_q <= in_data;
		if (cmd.mul1) x_q <= x_new;
		if (cmd.mul1 || cmd.mul2 || cmd.mul3) prod_q <= mres;
		if (cmd.div_start) sign_q <= v3[adnr_pkg::PROD_W-1];
		if (cmd.emit) begin
			kind_q <= 1'b0;
			right_q <= pan_q[0] ? '0 : s_clamp;
			left_q <= pan_q[1] ? '0 : s_clamp;
			play_out_q <= 1'b1;
			last_q <= last_n;
		end else if (cmd.stat) begin
			kind_q <= 1'b1;
			right_q <= '0;
			left_q <= '0;
			play_out_q <= playing_q;
			last_q <= 1'b1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.kind = kind_q;
	assign out_ch.right_sample = right_q;
	assign out_ch.left_sample = left_q;
	assign out_ch.playing = play_out_q;
	assign out_ch.last = last_q;

	always_comb begin
		st.in_valid = in_valid;
		st.op = adnr_pkg::op_t'(in_operation);
		st.playing = playing_q;
		st.cnt_lt_rate = cnt_lt_rate;
		st.capped = capped;
		st.nib = nib_q;
		st.div_busy = div_busy;
		st.out_free = out_free;
	end

	`ADNR_ASSERT(a_emit_in_phase, clk, arst_n, cmd.emit |-> cnt_lt_rate, "sample past rate")
	`ADNR_ASSERT(a_div_runs, clk, arst_n, cmd.div_start |=> div_busy, "divider not started")
	`ADNR_NEVER(a_no_emit_capped, clk, arst_n, cmd.emit && capped, "sample beyond cap")
endmodule

// ===== hdl/adpcm_nibble_decoder_resampler.sv =====
// top level: adpcm nibble decoder with cubic resampler
// a status read passes through S_STAT and waits for a free output register; controls act on acceptance
// each interpolated sample takes three passes of the reciprocal divider
// plus three multiply steps; a data byte gives up to 24 samples
// one item is worked at a time; the next is taken while the last result waits
// asynchronous active-low reset restores the decoder state and register defaults
module adpcm_nibble_decoder_resampler (
	input  logic clk,
	input  logic arst_n,
	adnr_in_if.sink in_ch,
	adnr_out_if.source out_ch,
	input  logic cfg_we,
	input  logic cfg_index,
	input  logic [2:0] cfg_data
);
	adnr_pkg::cmd_t cmd;
	adnr_pkg::stat_t st;
	logic in_ready;

	adnr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.st(st),
		.cmd(cmd),
		.in_ready(in_ready)
	);

	adnr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.in_valid(in_ch.valid),
		.in_operation(in_ch.operation),
		.in_data(in_ch.data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_ch(out_ch)
	);

	assign in_ch.ready = in_ready;
endmodule
